// ===== rtl/particle_bounce_integrator_core_assert.svh =====
`ifndef PARTICLE_BOUNCE_INTEGRATOR_CORE_ASSERT_SVH
`define PARTICLE_BOUNCE_INTEGRATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define PBI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pbi assertion failed");
`define PBI_CHECK_OUT(lbl, cond) \
  `PBI_ASSERT(lbl, out_valid |-> (cond))
`else
`define PBI_ASSERT(lbl, prop)
`define PBI_CHECK_OUT(lbl, cond)
`endif

`endif

// ===== rtl/pbi_pkg.sv =====
package pbi_pkg;

  localparam int DataW = 16;
  localparam int WideW = 34;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_GRAVITY    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_FRICTION   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_BOUNCINESS = 2'd2;

  localparam logic [DataW-1:0] GRAVITY_RST    = 16'd40141;
  localparam logic [DataW-1:0] FRICTION_RST   = 16'd32440;
  localparam logic [DataW-1:0] BOUNCINESS_RST = 16'd26214;

  localparam logic signed [DataW-1:0] POS_ONE = 16'sd4096;
  localparam logic signed [DataW-1:0] NEG_ONE = -16'sd4096;

  localparam logic signed [WideW-1:0] SAT_MAX = 34'sd32767;
  localparam logic signed [WideW-1:0] SAT_MIN = -34'sd32768;

  function automatic logic signed [DataW-1:0] sat16(input logic signed [WideW-1:0] x);
    logic signed [DataW-1:0] r;
    if (x > SAT_MAX) begin
      r = 16'sh7fff;
    end else if (x < SAT_MIN) begin
      r = 16'sh8000;
    end else begin
      r = x[DataW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/particle_bounce_integrator_core.sv =====
// Particle Euler step with floor and side wall bounce.
// Input: pulse start with in_pos_x/y, in_vel_x/y (signed Q4.12), in_time_step
// (unsigned Q0.16) and in_last_in. A word is taken on every edge with start
// high; busy is always low, so one particle can enter each clock.
// Output: out_valid strobes for one cycle with the updated particle, the
// hit_floor / hit_wall flags and out_last_out. Throughput is one particle per
// clock, set by six register stages, none holding more than one multiply level.
// Config: cfg_valid/cfg_ready with cfg_index (0 gravity, 1 friction,
// 2 bounciness) and cfg_wdata; cfg_ready is always high. Index 3 is ignored.
// Write config only with the pipeline empty.
// Reset: synchronous rst_n clears the pipeline valid bits and reloads the
// default gravity, friction and bounciness.
// The receiver cannot stall: each result appears exactly once, in order.
`include "particle_bounce_integrator_core_assert.svh"

module particle_bounce_integrator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [pbi_pkg::DataW-1:0]  in_pos_x,
  input  logic signed [pbi_pkg::DataW-1:0]  in_pos_y,
  input  logic signed [pbi_pkg::DataW-1:0]  in_vel_x,
  input  logic signed [pbi_pkg::DataW-1:0]  in_vel_y,
  input  logic        [pbi_pkg::DataW-1:0]  in_time_step,
  input  logic                              in_last_in,
  output logic                              out_valid,
  output logic signed [pbi_pkg::DataW-1:0]  out_new_pos_x,
  output logic signed [pbi_pkg::DataW-1:0]  out_new_pos_y,
  output logic signed [pbi_pkg::DataW-1:0]  out_new_vel_x,
  output logic signed [pbi_pkg::DataW-1:0]  out_new_vel_y,
  output logic                              out_hit_floor,
  output logic                              out_hit_wall,
  output logic                              out_last_out,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic        [pbi_pkg::CfgIdxW-1:0] cfg_index,
  input  logic        [pbi_pkg::DataW-1:0]  cfg_wdata
);
  import pbi_pkg::*;

  localparam int Stages = 6;

  logic [DataW-1:0] gravity_r, friction_r, bounce_r;
  logic [Stages-1:0] vld_r;
  logic accept;

  // stage 1
  logic        [DataW-1:0]  s1_g_r;
  logic signed [32:0]       s1_vxf_r;
  logic signed [DataW-1:0]  s1_px_r, s1_py_r, s1_vy_r;
  logic        [DataW-1:0]  s1_dt_r;
  logic                     s1_last_r;
  logic        [31:0]       gdt;
  // stage 2
  logic signed [17:0]       vy_sub;
  logic signed [17:0]       vxf_sh;
  logic signed [DataW-1:0]  s2_vx_r, s2_vy_r, s2_px_r, s2_py_r;
  logic        [DataW-1:0]  s2_dt_r;
  logic                     s2_last_r;
  // stage 3
  logic signed [32:0]       s3_vyf_r, s3_vxdt_r, s3_vxb_r;
  logic signed [DataW-1:0]  s3_vx_r, s3_px_r, s3_py_r;
  logic        [DataW-1:0]  s3_dt_r;
  logic                     s3_last_r;
  // stage 4
  logic signed [17:0]       vyf_sh;
  logic signed [16:0]       vxdt_sh;
  logic signed [17:0]       px_sum;
  logic signed [33:0]       vxb_neg;
  logic signed [DataW-1:0]  s4_vy_r, s4_px_r, s4_vx_r, s4_vxb_r, s4_py_r;
  logic        [DataW-1:0]  s4_dt_r;
  logic                     s4_last_r;
  // stage 5
  logic                     wall;
  logic signed [32:0]       s5_vydt_r, s5_vyb_r;
  logic signed [DataW-1:0]  s5_px_r, s5_vx_r, s5_py_r, s5_vy_r;
  logic                     s5_wall_r, s5_last_r;
  // stage 6
  logic signed [16:0]       vydt_sh;
  logic signed [17:0]       py_sum;
  logic signed [DataW-1:0]  py_sat;
  logic signed [33:0]       vyb_neg;
  logic                     floor_hit;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign out_valid = vld_r[Stages-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r <= GRAVITY_RST;
      friction_r <= FRICTION_RST;
      bounce_r <= BOUNCINESS_RST;
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[Stages-2:0], accept};
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_GRAVITY:    gravity_r <= cfg_wdata;
          REG_FRICTION:   friction_r <= cfg_wdata;
          REG_BOUNCINESS: bounce_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign gdt = gravity_r * in_time_step;

  always_ff @(posedge clk) begin
    s1_g_r    <= gdt[31:16];
    s1_vxf_r  <= in_vel_x * $signed({1'b0, friction_r});
    s1_px_r   <= in_pos_x;
    s1_py_r   <= in_pos_y;
    s1_vy_r   <= in_vel_y;
    s1_dt_r   <= in_time_step;
    s1_last_r <= in_last_in;
  end

  assign vy_sub = {{2{s1_vy_r[15]}}, s1_vy_r} - $signed({2'b00, s1_g_r});
  assign vxf_sh = 18'(s1_vxf_r >>> 15);

  always_ff @(posedge clk) begin
    s2_vy_r   <= sat16({{16{vy_sub[17]}}, vy_sub});
    s2_vx_r   <= sat16({{16{vxf_sh[17]}}, vxf_sh});
    s2_px_r   <= s1_px_r;
    s2_py_r   <= s1_py_r;
    s2_dt_r   <= s1_dt_r;
    s2_last_r <= s1_last_r;
  end

  always_ff @(posedge clk) begin
    s3_vyf_r  <= s2_vy_r * $signed({1'b0, friction_r});
    s3_vxdt_r <= s2_vx_r * $signed({1'b0, s2_dt_r});
    s3_vxb_r  <= s2_vx_r * $signed({1'b0, bounce_r});
    s3_vx_r   <= s2_vx_r;
    s3_px_r   <= s2_px_r;
    s3_py_r   <= s2_py_r;
    s3_dt_r   <= s2_dt_r;
    s3_last_r <= s2_last_r;
  end

  assign vyf_sh  = 18'(s3_vyf_r >>> 15);
  assign vxdt_sh = 17'(s3_vxdt_r >>> 16);
  assign px_sum  = {{2{s3_px_r[15]}}, s3_px_r} + {vxdt_sh[16], vxdt_sh};
  assign vxb_neg = -{s3_vxb_r[32], s3_vxb_r};

  always_ff @(posedge clk) begin
    s4_vy_r   <= sat16({{16{vyf_sh[17]}}, vyf_sh});
    s4_px_r   <= sat16({{16{px_sum[17]}}, px_sum});
    s4_vxb_r  <= sat16(vxb_neg >>> 15);
    s4_vx_r   <= s3_vx_r;
    s4_py_r   <= s3_py_r;
    s4_dt_r   <= s3_dt_r;
    s4_last_r <= s3_last_r;
  end

  assign wall = (s4_px_r < NEG_ONE) || (s4_px_r > POS_ONE);

  always_ff @(posedge clk) begin
    s5_vydt_r <= s4_vy_r * $signed({1'b0, s4_dt_r});
    s5_vyb_r  <= s4_vy_r * $signed({1'b0, bounce_r});
    s5_wall_r <= wall;
    s5_vx_r   <= wall ? s4_vxb_r : s4_vx_r;
    if (s4_px_r < NEG_ONE) begin
      s5_px_r <= NEG_ONE;
    end else if (s4_px_r > POS_ONE) begin
      s5_px_r <= POS_ONE;
    end else begin
      s5_px_r <= s4_px_r;
    end
    s5_py_r   <= s4_py_r;
    s5_vy_r   <= s4_vy_r;
    s5_last_r <= s4_last_r;
  end

  assign vydt_sh   = 17'(s5_vydt_r >>> 16);
  assign py_sum    = {{2{s5_py_r[15]}}, s5_py_r} + {vydt_sh[16], vydt_sh};
  assign py_sat    = sat16({{16{py_sum[17]}}, py_sum});
  assign floor_hit = py_sat < NEG_ONE;
  assign vyb_neg   = -{s5_vyb_r[32], s5_vyb_r};

  always_ff @(posedge clk) begin
    out_new_pos_x <= s5_px_r;
    out_new_pos_y <= floor_hit ? NEG_ONE : py_sat;
    out_new_vel_x <= s5_vx_r;
    out_new_vel_y <= floor_hit ? sat16(vyb_neg >>> 15) : s5_vy_r;
    out_hit_floor <= floor_hit;
    out_hit_wall  <= s5_wall_r;
    out_last_out  <= s5_last_r;
  end

  `PBI_ASSERT(a_latency, out_valid |-> $past(start, Stages))
  `PBI_CHECK_OUT(a_floor_clamp, !out_hit_floor || (out_new_pos_y == NEG_ONE))
  `PBI_CHECK_OUT(a_above_floor, out_new_pos_y >= NEG_ONE)
  `PBI_CHECK_OUT(a_wall_clamp,
    !out_hit_wall || (out_new_pos_x == NEG_ONE) || (out_new_pos_x == POS_ONE))

endmodule

// ===== test/particle_bounce_integrator_checker.sv =====
`timescale 1ns / 1ps

module particle_bounce_integrator_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               busy,
  input  logic signed [pbi_pkg::DataW-1:0]   in_pos_x,
  input  logic signed [pbi_pkg::DataW-1:0]   in_pos_y,
  input  logic signed [pbi_pkg::DataW-1:0]   in_vel_x,
  input  logic signed [pbi_pkg::DataW-1:0]   in_vel_y,
  input  logic        [pbi_pkg::DataW-1:0]   in_time_step,
  input  logic                               in_last_in,
  input  logic                               out_valid,
  input  logic signed [pbi_pkg::DataW-1:0]   out_new_pos_x,
  input  logic signed [pbi_pkg::DataW-1:0]   out_new_pos_y,
  input  logic signed [pbi_pkg::DataW-1:0]   out_new_vel_x,
  input  logic signed [pbi_pkg::DataW-1:0]   out_new_vel_y,
  input  logic                               out_hit_floor,
  input  logic                               out_hit_wall,
  input  logic                               out_last_out,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic        [pbi_pkg::CfgIdxW-1:0] cfg_index,
  input  logic        [pbi_pkg::DataW-1:0]   cfg_wdata,
  output int                                 mismatches,
  output int                                 pending_words,
  output int                                 words_checked,
  output int                                 floor_bounces,
  output int                                 wall_bounces
);

  typedef struct packed {
    logic signed [pbi_pkg::DataW-1:0] pos_x;
    logic signed [pbi_pkg::DataW-1:0] pos_y;
    logic signed [pbi_pkg::DataW-1:0] vel_x;
    logic signed [pbi_pkg::DataW-1:0] vel_y;
    logic                             hit_floor;
    logic                             hit_wall;
    logic                             last;
  } particle_word_t;

  logic [pbi_pkg::DataW-1:0] gravity_q;
  logic [pbi_pkg::DataW-1:0] friction_q;
  logic [pbi_pkg::DataW-1:0] bounce_q;

  particle_word_t expected_particles[$];
  particle_word_t exp_w;
  particle_word_t got_w;

  int errors_seen = 0;
  int checked = 0;
  int floors = 0;
  int walls = 0;

  assign mismatches    = errors_seen;
  assign words_checked = checked;
  assign floor_bounces = floors;
  assign wall_bounces  = walls;

  initial pending_words = 0;

  function automatic longint clamp_q12(input longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  // one Euler step with floor and wall bounce; shifts of signed values floor
  function automatic particle_word_t step_particle(
    input logic signed [pbi_pkg::DataW-1:0] px_i,
    input logic signed [pbi_pkg::DataW-1:0] py_i,
    input logic signed [pbi_pkg::DataW-1:0] vx_i,
    input logic signed [pbi_pkg::DataW-1:0] vy_i,
    input logic        [pbi_pkg::DataW-1:0] dt_i,
    input logic                             last_i,
    input logic        [pbi_pkg::DataW-1:0] grav_i,
    input logic        [pbi_pkg::DataW-1:0] fric_i,
    input logic        [pbi_pkg::DataW-1:0] bounce_i
  );
    longint px, py, vx, vy, dt, grav, fric, bounce;
    particle_word_t r;
    px = px_i;
    py = py_i;
    vx = vx_i;
    vy = vy_i;
    dt = dt_i;
    grav = grav_i;
    fric = fric_i;
    bounce = bounce_i;
    vy = clamp_q12(vy - ((grav * dt) >>> 16));
    vx = clamp_q12((vx * fric) >>> 15);
    vy = clamp_q12((vy * fric) >>> 15);
    px = clamp_q12(px + ((vx * dt) >>> 16));
    py = clamp_q12(py + ((vy * dt) >>> 16));
    r.hit_floor = (py < pbi_pkg::NEG_ONE);
    if (r.hit_floor) begin
      py = pbi_pkg::NEG_ONE;
      vy = clamp_q12((vy * -bounce) >>> 15);
    end
    r.hit_wall = (px < pbi_pkg::NEG_ONE) || (px > pbi_pkg::POS_ONE);
    if (r.hit_wall) begin
      vx = clamp_q12((vx * -bounce) >>> 15);
      px = (px < 0) ? pbi_pkg::NEG_ONE : pbi_pkg::POS_ONE;
    end
    r.pos_x = px[15:0];
    r.pos_y = py[15:0];
    r.vel_x = vx[15:0];
    r.vel_y = vy[15:0];
    r.last = last_i;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      gravity_q  <= pbi_pkg::GRAVITY_RST;
      friction_q <= pbi_pkg::FRICTION_RST;
      bounce_q   <= pbi_pkg::BOUNCINESS_RST;
      expected_particles.delete();
      pending_words <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pbi_pkg::REG_GRAVITY:    gravity_q  <= cfg_wdata;
          pbi_pkg::REG_FRICTION:   friction_q <= cfg_wdata;
          pbi_pkg::REG_BOUNCINESS: bounce_q   <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid) begin
        got_w = '{out_new_pos_x, out_new_pos_y, out_new_vel_x, out_new_vel_y,
                  out_hit_floor, out_hit_wall, out_last_out};
        if (expected_particles.size() == 0) begin
          if (errors_seen < 10)
            $display("%0t: unexpected word px=%0d py=%0d vx=%0d vy=%0d", $realtime,
                     got_w.pos_x, got_w.pos_y, got_w.vel_x, got_w.vel_y);
          errors_seen++;
        end else begin
          exp_w = expected_particles.pop_front();
          checked++;
          if (exp_w.pos_x !== got_w.pos_x || exp_w.pos_y !== got_w.pos_y ||
              exp_w.vel_x !== got_w.vel_x || exp_w.vel_y !== got_w.vel_y ||
              exp_w.hit_floor !== got_w.hit_floor || exp_w.hit_wall !== got_w.hit_wall ||
              exp_w.last !== got_w.last) begin
            if (errors_seen < 10) begin
              $display("%0t: mismatch exp px=%0d py=%0d vx=%0d vy=%0d fl=%b wl=%b last=%b",
                       $realtime, exp_w.pos_x, exp_w.pos_y, exp_w.vel_x, exp_w.vel_y,
                       exp_w.hit_floor, exp_w.hit_wall, exp_w.last);
              $display("           got px=%0d py=%0d vx=%0d vy=%0d fl=%b wl=%b last=%b",
                       got_w.pos_x, got_w.pos_y, got_w.vel_x, got_w.vel_y,
                       got_w.hit_floor, got_w.hit_wall, got_w.last);
            end
            errors_seen++;
          end
        end
      end
      if (start && !busy) begin
        exp_w = step_particle(in_pos_x, in_pos_y, in_vel_x, in_vel_y, in_time_step,
                              in_last_in, gravity_q, friction_q, bounce_q);
        if (exp_w.hit_floor) floors++;
        if (exp_w.hit_wall) walls++;
        expected_particles.push_back(exp_w);
      end
      pending_words <= expected_particles.size();
    end
  end

endmodule

// ===== test/tb_particle_bounce_integrator_core.sv =====
`timescale 1ns / 1ps

module tb_particle_bounce_integrator_core;

  localparam logic [pbi_pkg::CfgIdxW-1:0] REG_UNUSED = 2'd3;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               start = 1'b0;
  logic                               busy;
  logic signed [pbi_pkg::DataW-1:0]   in_pos_x = '0;
  logic signed [pbi_pkg::DataW-1:0]   in_pos_y = '0;
  logic signed [pbi_pkg::DataW-1:0]   in_vel_x = '0;
  logic signed [pbi_pkg::DataW-1:0]   in_vel_y = '0;
  logic        [pbi_pkg::DataW-1:0]   in_time_step = '0;
  logic                               in_last_in = 1'b0;
  logic                               out_valid;
  logic signed [pbi_pkg::DataW-1:0]   out_new_pos_x;
  logic signed [pbi_pkg::DataW-1:0]   out_new_pos_y;
  logic signed [pbi_pkg::DataW-1:0]   out_new_vel_x;
  logic signed [pbi_pkg::DataW-1:0]   out_new_vel_y;
  logic                               out_hit_floor;
  logic                               out_hit_wall;
  logic                               out_last_out;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic        [pbi_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic        [pbi_pkg::DataW-1:0]   cfg_wdata = '0;

  int mismatches;
  int pending_words;
  int words_checked;
  int floor_bounces;
  int wall_bounces;

  logic idle_on = 1'b1;
  int   settings_used = 1;
  int   total_errors;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  particle_bounce_integrator_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_vel_x(in_vel_x), .in_vel_y(in_vel_y),
    .in_time_step(in_time_step), .in_last_in(in_last_in),
    .out_valid(out_valid), .out_new_pos_x(out_new_pos_x), .out_new_pos_y(out_new_pos_y),
    .out_new_vel_x(out_new_vel_x), .out_new_vel_y(out_new_vel_y),
    .out_hit_floor(out_hit_floor), .out_hit_wall(out_hit_wall), .out_last_out(out_last_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  particle_bounce_integrator_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_vel_x(in_vel_x), .in_vel_y(in_vel_y),
    .in_time_step(in_time_step), .in_last_in(in_last_in),
    .out_valid(out_valid), .out_new_pos_x(out_new_pos_x), .out_new_pos_y(out_new_pos_y),
    .out_new_vel_x(out_new_vel_x), .out_new_vel_y(out_new_vel_y),
    .out_hit_floor(out_hit_floor), .out_hit_wall(out_hit_wall), .out_last_out(out_last_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .pending_words(pending_words), .words_checked(words_checked),
    .floor_bounces(floor_bounces), .wall_bounces(wall_bounces)
  );

  task automatic send_particle(input logic [15:0] px, input logic [15:0] py,
                               input logic [15:0] vx, input logic [15:0] vy,
                               input logic [15:0] dt, input logic last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start        <= 1'b1;
    in_pos_x     <= px;
    in_pos_y     <= py;
    in_vel_x     <= vx;
    in_vel_y     <= vy;
    in_time_step <= dt;
    in_last_in   <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [pbi_pkg::CfgIdxW-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // unused index goes last so any aliasing onto a real register shows up
  task automatic program_regs(input logic [15:0] g, input logic [15:0] f,
                              input logic [15:0] b);
    drain();
    cfg_write(pbi_pkg::REG_GRAVITY, g);
    cfg_write(pbi_pkg::REG_FRICTION, f);
    cfg_write(pbi_pkg::REG_BOUNCINESS, b);
    cfg_write(REG_UNUSED, 16'($urandom()));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [15:0] rand_coord();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom_range(0, 65535);
      3, 4, 5, 6: begin
        v = $urandom_range(0, 10000);
        v = v - 5000;
      end
      default: begin
        v = $urandom_range(0, 8400);
        v = v - 4200;
      end
    endcase
    return v[15:0];
  endfunction

  function automatic logic [15:0] rand_vel();
    int v;
    if ($urandom_range(0, 9) < 3) begin
      v = $urandom_range(0, 65535);
    end else begin
      v = $urandom_range(0, 16383);
      v = v - 8192;
    end
    return v[15:0];
  endfunction

  function automatic logic [15:0] rand_dt();
    if ($urandom_range(0, 9) < 3) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(0, 2000));
  endfunction

  task automatic random_batch(input int count, input logic allow_idle);
    for (int i = 0; i < count; i++) begin
      if (i % 32 == 0) idle_on = allow_idle && ($urandom_range(0, 2) != 0);
      send_particle(rand_coord(), rand_coord(), rand_vel(), rand_vel(), rand_dt(),
                    $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values
    send_particle(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b0);
    send_particle(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b1);
    send_particle(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'hffff, 1'b1);
    send_particle(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'hffff, 1'b0);
    send_particle(16'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b0);
    send_particle(16'sd4097, 16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b0);
    send_particle(-16'sd4097, 16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b0);
    send_particle(-16'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b0);
    send_particle(16'sd0, -16'sd4096, 16'sd0, 16'sd0, 16'd0, 1'b0);
    send_particle(16'sd0, -16'sd4097, 16'sd0, 16'sd0, 16'd0, 1'b0);
    send_particle(16'sd5000, -16'sd5000, 16'sd3000, -16'sd3000, 16'd2000, 1'b1);
    send_particle(16'sd0, 16'sd0, 16'sd0, 16'sh8000, 16'hffff, 1'b0);
    send_particle(16'sd0, 16'sd0, 16'sh7fff, 16'sd0, 16'hffff, 1'b0);
    send_particle(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'd1, 1'b0);
    send_particle(16'sd0, -16'sd4000, 16'sd0, 16'sd0, 16'hffff, 1'b0);
    send_particle(16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555, 16'haaaa, 1'b1);
    send_particle(16'shaaaa, 16'sh5555, 16'sh5555, 16'shaaaa, 16'h5555, 1'b0);

    program_regs(16'd0, 16'd32768, 16'd32768);
    random_batch(160, 1'b1);
    program_regs(16'hffff, 16'd0, 16'd0);
    random_batch(160, 1'b1);
    // factors above one act as gains
    program_regs(16'hffff, 16'hffff, 16'hffff);
    random_batch(160, 1'b1);
    repeat (4) begin
      program_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(28000, 32768)),
                   16'($urandom_range(0, 32768)));
      random_batch(160, 1'b1);
    end
    program_regs(pbi_pkg::GRAVITY_RST, pbi_pkg::FRICTION_RST, pbi_pkg::BOUNCINESS_RST);
    random_batch(160, 1'b0);

    drain();
    repeat (12) @(posedge clk);
    total_errors = mismatches + pending_words;
    $display("Covered %0d particles under %0d register settings (%0d floor, %0d wall bounces).",
             words_checked, settings_used, floor_bounces, wall_bounces);
    if (total_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
